[rtl/osq_pkg.sv]
// Shared types and constants of the ordered timer queue.
package osq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int ID_W       = 4;
    localparam int TICK_W     = 32;
    localparam int OP_W       = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
    localparam logic [OP_W-1:0] OP_START   = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd2;
    localparam logic [OP_W-1:0] OP_RUN     = 2'd3;

    // Cell commands
    localparam logic [2:0] CMD_HOLD       = 3'd0;
    localparam logic [2:0] CMD_TAKE_RIGHT = 3'd1;
    localparam logic [2:0] CMD_TAKE_LEFT  = 3'd2;
    localparam logic [2:0] CMD_LOAD       = 3'd3;
    localparam logic [2:0] CMD_MARK       = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic              periodic;
        logic              expired;
        logic [TICK_W-1:0] expiry;
        logic [TICK_W-1:0] period;
    } entry_t;

    typedef struct packed {
        logic [2:0]        cmd;
        entry_t            load;
        logic [ID_W-1:0]   target;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] pending;
        logic [TICK_W-1:0] key;
    } cell_ctrl_t;

    typedef struct packed {
        logic              match;
        logic              stop;
        logic              due;
        logic [TICK_W-1:0] left;
    } cell_stat_t;

endpackage

[rtl/osq_cell.sv]
// One queue position: holds an entry and shifts it to either neighbor.
module osq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  osq_pkg::cell_ctrl_t ctrl,
    input  osq_pkg::entry_t     from_left,
    input  osq_pkg::entry_t     from_right,
    output osq_pkg::entry_t     entry,
    output osq_pkg::cell_stat_t stat
);
    import osq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    entry_t            data_reg;
    entry_t            data_next;
    logic [TICK_W-1:0] rem;

    // Pick the next content
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctrl.cmd)
            CMD_TAKE_RIGHT:
            begin
                valid_next = from_right.valid;
                data_next  = from_right;
            end
            CMD_TAKE_LEFT:
            begin
                valid_next = from_left.valid;
                data_next  = from_left;
            end
            CMD_LOAD:
            begin
                valid_next = 1'b1;
                data_next  = ctrl.load;
            end
            CMD_MARK:
            begin
                data_next.expired = 1'b1;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Report remaining ticks and compare flags
    assign rem = data_reg.expiry - ctrl.now;

    always_comb
    begin
        entry       = data_reg;
        entry.valid = valid_reg;
        stat.left   = (!data_reg.expired && rem > ctrl.pending) ? rem - ctrl.pending : '0;
        stat.match  = valid_reg && (data_reg.id == ctrl.target);
        stat.stop   = !valid_reg || (ctrl.key < stat.left);
        stat.due    = valid_reg && (data_reg.expired || rem <= ctrl.pending);
    end

endmodule

[rtl/ordered_software_timer_queue.sv]
// Top level of the ordered timer queue: sequencer and the row of cells.
//
// Requests enter on the s_ group: s_tuser carries the operation (advance,
// start, stop, run) and s_tdata the timer id, tick count and periodic flag.
// Each request gives exactly one result on the m_ group: m_tuser is the
// fired flag, m_tdata the fired id and the head's remaining ticks (all ones
// when the queue is empty).
// The timers sit in a row of 16 cells sorted by remaining ticks; each cell
// compares its own entry, and the cells from the removal or insertion
// point on shift by one place. An advance goes straight to its result; a
// stop passes the remove state, a start the remove and insert states, a run
// mark and serve, then remove on a fire and insert on a periodic fire.
// One request is in work at a time; a new request is taken when the
// sequencer is idle, in the cycle after the last result is loaded, even while
// that result still waits on m_tready.
// A stalled receiver holds the next result in its final stage.
// Reset empties the queue and clears the time and pending counts.
module ordered_software_timer_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // timer_id[3:0], ticks[35:4], periodic[36], zero pad
    input  logic [1:0]  s_tuser,  // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // fired_id[3:0], next_remaining[35:4], zero pad
    output logic        m_tuser   // fired
);
    import osq_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REMOVE = 3'd1;
    localparam logic [2:0] ST_INSERT = 3'd2;
    localparam logic [2:0] ST_MARK   = 3'd3;
    localparam logic [2:0] ST_SERVE  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [TICK_W-1:0] now_reg, now_next;
    logic [TICK_W-1:0] pending_reg, pending_next;
    entry_t            temp_reg, temp_next;
    logic [ID_W-1:0]   target_reg, target_next;
    logic              ins_pend_reg, ins_pend_next;
    logic              fired_reg, fired_next;
    logic [ID_W-1:0]   fired_id_reg, fired_id_next;
    logic              out_valid_reg;
    logic              out_fired_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [TICK_W-1:0] out_next_reg;

    entry_t            cell_entry [NUM_TIMERS];
    cell_stat_t        cell_stat  [NUM_TIMERS];
    cell_ctrl_t        cell_ctrl  [NUM_TIMERS];
    entry_t            empty_entry;
    logic [NUM_TIMERS-1:0] rm_pre, stop_pre, mark_pre, valid_vec;
    logic [TICK_W-1:0] temp_rem, key;
    logic              accept, out_load;

    logic [1:0]        in_op;
    logic [ID_W-1:0]   in_id;
    logic [TICK_W-1:0] in_ticks;
    logic              in_periodic;

    assign in_op       = s_tuser;
    assign in_id       = s_tdata[3:0];
    assign in_ticks    = s_tdata[35:4];
    assign in_periodic = s_tdata[36];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || m_tready);

    // Key of the entry being inserted
    assign temp_rem = temp_reg.expiry - now_reg;
    assign key      = (temp_rem > pending_reg) ? temp_rem - pending_reg : '0;

    always_comb
    begin
        empty_entry = '0;
    end

    // Prefix flags across the row
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            valid_vec[i] = cell_entry[i].valid;
            if (i == 0)
            begin
                rm_pre[i]   = cell_stat[i].match;
                stop_pre[i] = cell_stat[i].stop;
                mark_pre[i] = cell_stat[i].due;
            end
            else
            begin
                rm_pre[i]   = rm_pre[i-1] || cell_stat[i].match;
                stop_pre[i] = stop_pre[i-1] || cell_stat[i].stop;
                mark_pre[i] = mark_pre[i-1] && cell_stat[i].due;
            end
        end
    end

    // Per-cell commands
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            cell_ctrl[i].load    = temp_reg;
            cell_ctrl[i].target  = target_reg;
            cell_ctrl[i].now     = now_reg;
            cell_ctrl[i].pending = pending_reg;
            cell_ctrl[i].key     = key;
            cell_ctrl[i].cmd     = CMD_HOLD;
            unique case (state_reg)
                ST_REMOVE:
                begin
                    if (rm_pre[i])
                        cell_ctrl[i].cmd = CMD_TAKE_RIGHT;
                end
                ST_INSERT:
                begin
                    if (i > 0 && stop_pre[i-1])
                        cell_ctrl[i].cmd = CMD_TAKE_LEFT;
                    else if (stop_pre[i])
                        cell_ctrl[i].cmd = CMD_LOAD;
                end
                ST_MARK:
                begin
                    if (mark_pre[i])
                        cell_ctrl[i].cmd = CMD_MARK;
                end
                default:
                begin
                    cell_ctrl[i].cmd = CMD_HOLD;
                end
            endcase
        end
    end

    // Row of cells
    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_cell
        osq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[g]),
            .from_left  ((g == 0) ? empty_entry : cell_entry[(g == 0) ? 0 : g-1]),
            .from_right ((g == NUM_TIMERS-1) ? empty_entry
                         : cell_entry[(g == NUM_TIMERS-1) ? g : g+1]),
            .entry      (cell_entry[g]),
            .stat       (cell_stat[g])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        pending_next  = pending_reg;
        temp_next     = temp_reg;
        target_next   = target_reg;
        ins_pend_next = ins_pend_reg;
        fired_next    = fired_reg;
        fired_id_next = fired_id_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fired_next    = 1'b0;
                    fired_id_next = '0;
                    target_next   = in_id;
                    unique case (in_op)
                        OP_ADVANCE:
                        begin
                            pending_next = pending_reg + in_ticks;
                            state_next   = ST_RESULT;
                        end
                        OP_START:
                        begin
                            temp_next.valid    = 1'b1;
                            temp_next.id       = in_id;
                            temp_next.periodic = in_periodic;
                            temp_next.expired  = 1'b0;
                            temp_next.expiry   = now_reg + in_ticks + pending_reg;
                            temp_next.period   = in_ticks;
                            ins_pend_next      = 1'b1;
                            state_next         = ST_REMOVE;
                        end
                        OP_STOP:
                        begin
                            ins_pend_next = 1'b0;
                            state_next    = ST_REMOVE;
                        end
                        default:
                        begin
                            state_next = ST_MARK;
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                now_next     = now_reg + pending_reg;
                pending_next = '0;
                state_next   = ST_SERVE;
            end
            ST_SERVE:
            begin
                if (cell_entry[0].valid && cell_entry[0].expired)
                begin
                    fired_next       = 1'b1;
                    fired_id_next    = cell_entry[0].id;
                    target_next      = cell_entry[0].id;
                    temp_next        = cell_entry[0];
                    temp_next.expired = 1'b0;
                    temp_next.expiry = now_reg + cell_entry[0].period;
                    ins_pend_next    = cell_entry[0].periodic;
                    state_next       = ST_REMOVE;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_REMOVE:
            begin
                state_next = ins_pend_reg ? ST_INSERT : ST_RESULT;
            end
            ST_INSERT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            pending_reg <= pending_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold request payload and result
    always_ff @(posedge clk)
    begin
        temp_reg     <= temp_next;
        target_reg   <= target_next;
        ins_pend_reg <= ins_pend_next;
        fired_reg    <= fired_next;
        fired_id_reg <= fired_id_next;
        if (out_load)
        begin
            out_fired_reg <= fired_reg;
            out_id_reg    <= fired_id_reg;
            out_next_reg  <= cell_entry[0].valid ? cell_stat[0].left : '1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_fired_reg;
    assign m_tdata  = {4'b0000, out_next_reg, out_id_reg};

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("sequencer stayed idle after a request");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{NUM_TIMERS{1'b0}}, 1'b1}))
        else $error("queue cells not packed from the head");

    a_serve_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SERVE && !cell_entry[0].valid) |=> state_reg == ST_RESULT)
        else $error("run on empty queue did not go to result");

endmodule
